// ===== hw/rtl/gradient_noise_2d_fractal_sum_defines.svh =====
// assertion macros for the fractal gradient noise block
// used by the rtl files that carry concurrent checks
`ifndef GRADIENT_NOISE_2D_FRACTAL_SUM_DEFINES_SVH
`define GRADIENT_NOISE_2D_FRACTAL_SUM_DEFINES_SVH
`ifndef SYNTHESIS
`define GNFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GNFS_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GNFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define GNFS_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/gnfs_pkg.sv =====
// shared types, constants and helper functions of the fractal gradient noise block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gnfs_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int TW              = $clog2(TABLE_SIZE);
    localparam int MAX_OCTAVES_DEF = 16;

    localparam int TDATA_W    = 112;
    localparam int TUSER_W    = 2;
    localparam int NOISE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DOT_W      = 20;
    localparam int QUO_W      = 15;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int DEN_W      = 18;

    typedef logic [TUSER_W-1:0] op_t;
    localparam op_t OP_LOAD_PERM = 2'd0;
    localparam op_t OP_LOAD_GRAD = 2'd1;
    localparam op_t OP_EVAL      = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_OCTAVES = 2'd0;
    localparam cfg_idx_t REG_PERSIST = 2'd1;
    localparam cfg_idx_t REG_LACUN   = 2'd2;

    localparam logic [4:0]       OCTAVES_RST = 5'd4;
    localparam logic [15:0]      PERSIST_RST = 16'h8000;
    localparam logic [15:0]      LACUN_RST   = 16'h2000;
    localparam logic [16:0]      SCALE_ONE   = 17'h10000;
    localparam logic [DEN_W-1:0] DEN_ONE     = 18'h10000;
    localparam logic [DEN_W-1:0] DEN_TWO     = 18'h20000;
    localparam logic [17:0]      FADE_THREE  = 18'h30000;

    localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7FFF;
    localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

    typedef struct packed {
        logic        first;
        logic        last;
        logic        zero;
        logic [16:0] scale;
        logic [16:0] scale_nx;
    } tag_t;

    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
    } div_t;

    // restoring division, a few quotient bits per call
    function automatic div_t div_steps(div_t a);
        div_t           r;
        logic [DEN_W:0] sh;
        r = a;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            sh = {r.rem, 1'b0};
            if (sh >= {1'b0, r.den})
            begin
                r.rem = DEN_W'(sh - {1'b0, r.den});
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = sh[DEN_W-1:0];
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gradient_noise_2d_fractal_sum.sv =====
// fractal 2d gradient noise: table loads, octave pipeline, normalizing divider
// depends on gnfs_pkg and gradient_noise_2d_fractal_sum_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_noise_2d_fractal_sum_defines.svh"

// Usage
// s_* carries items: s_tuser is the operation (load perm entry, load gradient
// entry, evaluate point); s_tdata holds table index, perm value, gradients and
// the Q16.16 point. Loads give no result, an evaluate gives one noise sample on
// m_tdata. cfg_* writes octave count, persistence and lacunarity; cfg_ready is
// always high; writes are to be made while the block is idle, which the block
// itself does not enforce. An evaluate occupies the octave issue stage until it
// has sent max(1, n) octave items, n the octave count; unless the pipeline
// stalls, the issue stage sends one octave per cycle into a 10-stage octave
// pipeline, then a 7-stage normalize and divide section. A load is written to
// its table once evaluates ahead of it have passed the table reads.
// Reset clears control and presets the config; tables are undefined until loaded.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps filling its empty stages; it freezes only when its last
// stage and the output register are both full.
module gradient_noise_2d_fractal_sum #(
    parameter int MAX_OCTAVES = gnfs_pkg::MAX_OCTAVES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // tdata: table_index[7:0], perm_value[15:8], grad_x[31:16], grad_y[47:32],
    //        coord_x[79:48], coord_y[111:80]
    input  wire logic [gnfs_pkg::TDATA_W-1:0]    s_tdata,
    // tuser: operation[1:0]
    input  wire logic [gnfs_pkg::TUSER_W-1:0]    s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: noise_value[15:0]
    output logic [gnfs_pkg::NOISE_W-1:0]         m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gnfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gnfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gnfs_pkg::*;

    localparam int CW    = $clog2(MAX_OCTAVES + 1);
    localparam int SUM_W = DOT_W + $clog2(MAX_OCTAVES);
    localparam int NST   = 10;

    // configuration
    logic [4:0]  oct_reg;
    logic [15:0] pers_reg;
    logic [15:0] lac_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg  <= OCTAVES_RST;
            pers_reg <= PERSIST_RST;
            lac_reg  <= LACUN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OCTAVES: oct_reg  <= cfg_data[4:0];
                REG_PERSIST: pers_reg <= cfg_data;
                REG_LACUN:   lac_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // issue stage
    logic            busy_reg;
    logic            first_reg;
    logic [CW-1:0]   rem_reg;
    op_t             hold_op_reg;
    logic [7:0]      hold_idx_reg;
    logic [7:0]      hold_pv_reg;
    logic [31:0]     hold_grad_reg;
    logic [31:0]     px_reg;
    logic [31:0]     py_reg;
    logic [16:0]     scale_reg;

    logic            adv;
    logic            rd_busy;
    logic            is_eval;
    logic            emit;
    logic            issue_last;
    logic            load_done;
    logic            done_now;
    logic            accept;
    logic            perm_we;
    logic            grad_we;
    logic [CW-1:0]   oct_sat;
    logic [32:0]     scale_prod;
    logic [16:0]     scale_nx;
    logic signed [48:0] px_prod;
    logic signed [48:0] py_prod;

    logic            v_reg   [1:NST];
    tag_t            tag_reg [1:NST];

    assign rd_busy    = v_reg[1] || v_reg[2] || v_reg[3];
    assign is_eval    = (hold_op_reg == OP_EVAL);
    assign emit       = busy_reg && is_eval && adv;
    assign issue_last = (rem_reg <= CW'(1));
    assign load_done  = busy_reg && !is_eval && !rd_busy;
    assign done_now   = load_done || (emit && issue_last);
    assign s_tready   = !busy_reg || done_now;
    assign accept     = s_tvalid && s_tready;
    assign perm_we    = load_done && (hold_op_reg == OP_LOAD_PERM);
    assign grad_we    = load_done && (hold_op_reg == OP_LOAD_GRAD);

    assign oct_sat    = ({1'b0, oct_reg} > 6'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(oct_reg);
    assign scale_prod = scale_reg * pers_reg;
    assign scale_nx   = scale_prod[32:16];
    assign px_prod    = $signed(px_reg) * $signed({1'b0, lac_reg});
    assign py_prod    = $signed(py_reg) * $signed({1'b0, lac_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else if (accept)
        begin
            busy_reg  <= 1'b1;
            first_reg <= 1'b1;
            rem_reg   <= oct_sat;
        end
        else if (done_now)
        begin
            busy_reg <= 1'b0;
        end
        else if (emit)
        begin
            first_reg <= 1'b0;
            rem_reg   <= rem_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_op_reg   <= s_tuser;
            hold_idx_reg  <= s_tdata[7:0];
            hold_pv_reg   <= s_tdata[15:8];
            hold_grad_reg <= s_tdata[47:16];
            px_reg        <= s_tdata[79:48];
            py_reg        <= s_tdata[111:80];
            scale_reg     <= SCALE_ONE;
        end
        else if (emit)
        begin
            px_reg    <= px_prod[43:12];
            py_reg    <= py_prod[43:12];
            scale_reg <= scale_nx;
        end
    end

    // valid and tag shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[1] <= emit;
            for (int k = 2; k <= NST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[1].first    <= first_reg;
            tag_reg[1].last     <= issue_last;
            tag_reg[1].zero     <= (rem_reg == '0);
            tag_reg[1].scale    <= scale_reg;
            tag_reg[1].scale_nx <= (rem_reg == '0) ? scale_reg : scale_nx;
            for (int k = 2; k <= NST; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // tables, replicated for parallel reads
    logic [TW-1:0] perm0_mem [TABLE_SIZE];
    logic [TW-1:0] perm1_mem [TABLE_SIZE];
    logic [TW-1:0] perm2_mem [TABLE_SIZE];
    logic [31:0]   grad0_mem [TABLE_SIZE];
    logic [31:0]   grad1_mem [TABLE_SIZE];

    // octave pipeline registers
    logic [TW-1:0] s1_bx_reg, s1_by_reg;
    logic [15:0]   s1_rx_reg, s1_ry_reg;
    logic [TW-1:0] s2_pi_reg, s2_pj_reg, s2_by_reg;
    logic [15:0]   s2_rx_reg, s2_ry_reg, s2_t2x_reg, s2_t2y_reg;
    logic [TW-1:0] s3_c_reg [0:3];
    logic [15:0]   s3_rx_reg, s3_ry_reg, s3_sx_reg, s3_sy_reg;
    logic [31:0]   s4_g_reg [0:3];
    logic [15:0]   s4_rx_reg, s4_ry_reg, s4_sx_reg, s4_sy_reg;
    logic signed [32:0] s5_p_reg [0:7];
    logic [15:0]   s5_sx_reg, s5_sy_reg;
    logic signed [DOT_W-1:0] s6_d_reg [0:3];
    logic [15:0]   s6_sx_reg, s6_sy_reg;
    logic signed [37:0] s7_m0_reg, s7_m1_reg;
    logic signed [DOT_W-1:0] s7_a0_reg, s7_a1_reg;
    logic [15:0]   s7_sy_reg;
    logic signed [DOT_W-1:0] s8_a_reg, s8_b_reg;
    logic [15:0]   s8_sy_reg;
    logic signed [DOT_W-1:0] s9_a_reg;
    logic signed [37:0] s9_m_reg;
    logic signed [37:0] s10_prod_reg;

    // combinational per stage
    logic [TW-1:0] bx1_c, by1_c;
    logic [31:0]   sqx_c, sqy_c;
    logic [33:0]   fx_c, fy_c;
    logic [TW-1:0] a_c [0:3];
    logic signed [16:0] rx0_c, rx1_c, ry0_c, ry1_c;
    logic signed [32:0] p_c [0:7];
    logic signed [33:0] dsum_c [0:3];
    logic signed [20:0] dx0_c, dx1_c, dy_c;
    logic signed [37:0] m0_c, m1_c, my_c;
    logic signed [21:0] la_c, lb_c, nz_c;
    logic signed [DOT_W-1:0] noise_c;
    logic signed [37:0] wprod_c;

    always_comb
    begin
        bx1_c = s1_bx_reg + TW'(1);
        sqx_c = s1_rx_reg * s1_rx_reg;
        sqy_c = s1_ry_reg * s1_ry_reg;

        by1_c = s2_by_reg + TW'(1);
        a_c[0] = s2_pi_reg + s2_by_reg;
        a_c[1] = s2_pj_reg + s2_by_reg;
        a_c[2] = s2_pi_reg + by1_c;
        a_c[3] = s2_pj_reg + by1_c;
        fx_c = s2_t2x_reg * (FADE_THREE - {1'b0, s2_rx_reg, 1'b0});
        fy_c = s2_t2y_reg * (FADE_THREE - {1'b0, s2_ry_reg, 1'b0});

        rx0_c = $signed({1'b0, s4_rx_reg});
        rx1_c = $signed({1'b1, s4_rx_reg});
        ry0_c = $signed({1'b0, s4_ry_reg});
        ry1_c = $signed({1'b1, s4_ry_reg});
        p_c[0] = $signed(s4_g_reg[0][15:0])  * rx0_c;
        p_c[1] = $signed(s4_g_reg[0][31:16]) * ry0_c;
        p_c[2] = $signed(s4_g_reg[1][15:0])  * rx1_c;
        p_c[3] = $signed(s4_g_reg[1][31:16]) * ry0_c;
        p_c[4] = $signed(s4_g_reg[2][15:0])  * rx0_c;
        p_c[5] = $signed(s4_g_reg[2][31:16]) * ry1_c;
        p_c[6] = $signed(s4_g_reg[3][15:0])  * rx1_c;
        p_c[7] = $signed(s4_g_reg[3][31:16]) * ry1_c;

        for (int k = 0; k < 4; k++)
        begin
            dsum_c[k] = 34'(s5_p_reg[2*k]) + 34'(s5_p_reg[2*k+1]);
        end

        dx0_c = 21'(s6_d_reg[1]) - 21'(s6_d_reg[0]);
        dx1_c = 21'(s6_d_reg[3]) - 21'(s6_d_reg[2]);
        m0_c  = dx0_c * $signed({1'b0, s6_sx_reg});
        m1_c  = dx1_c * $signed({1'b0, s6_sx_reg});

        la_c = 22'(s7_a0_reg) + $signed(s7_m0_reg[37:16]);
        lb_c = 22'(s7_a1_reg) + $signed(s7_m1_reg[37:16]);

        dy_c = 21'(s8_b_reg) - 21'(s8_a_reg);
        my_c = dy_c * $signed({1'b0, s8_sy_reg});

        nz_c    = 22'(s9_a_reg) + $signed(s9_m_reg[37:16]);
        noise_c = nz_c[DOT_W-1:0];
        wprod_c = noise_c * $signed({1'b0, tag_reg[9].scale});
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm0_mem[hold_idx_reg[TW-1:0]] <= hold_pv_reg[TW-1:0];
            perm1_mem[hold_idx_reg[TW-1:0]] <= hold_pv_reg[TW-1:0];
            perm2_mem[hold_idx_reg[TW-1:0]] <= hold_pv_reg[TW-1:0];
        end
        if (grad_we)
        begin
            grad0_mem[hold_idx_reg[TW-1:0]] <= hold_grad_reg;
            grad1_mem[hold_idx_reg[TW-1:0]] <= hold_grad_reg;
        end
        if (adv)
        begin
            s1_bx_reg <= px_reg[16+TW-1:16];
            s1_by_reg <= py_reg[16+TW-1:16];
            s1_rx_reg <= px_reg[15:0];
            s1_ry_reg <= py_reg[15:0];

            s2_pi_reg  <= perm0_mem[s1_bx_reg];
            s2_pj_reg  <= perm0_mem[bx1_c];
            s2_by_reg  <= s1_by_reg;
            s2_rx_reg  <= s1_rx_reg;
            s2_ry_reg  <= s1_ry_reg;
            s2_t2x_reg <= sqx_c[31:16];
            s2_t2y_reg <= sqy_c[31:16];

            s3_c_reg[0] <= perm1_mem[a_c[0]];
            s3_c_reg[1] <= perm1_mem[a_c[1]];
            s3_c_reg[2] <= perm2_mem[a_c[2]];
            s3_c_reg[3] <= perm2_mem[a_c[3]];
            s3_rx_reg   <= s2_rx_reg;
            s3_ry_reg   <= s2_ry_reg;
            s3_sx_reg   <= fx_c[31:16];
            s3_sy_reg   <= fy_c[31:16];

            s4_g_reg[0] <= grad0_mem[s3_c_reg[0]];
            s4_g_reg[1] <= grad0_mem[s3_c_reg[1]];
            s4_g_reg[2] <= grad1_mem[s3_c_reg[2]];
            s4_g_reg[3] <= grad1_mem[s3_c_reg[3]];
            s4_rx_reg   <= s3_rx_reg;
            s4_ry_reg   <= s3_ry_reg;
            s4_sx_reg   <= s3_sx_reg;
            s4_sy_reg   <= s3_sy_reg;

            for (int k = 0; k < 8; k++)
            begin
                s5_p_reg[k] <= p_c[k];
            end
            s5_sx_reg <= s4_sx_reg;
            s5_sy_reg <= s4_sy_reg;

            for (int k = 0; k < 4; k++)
            begin
                s6_d_reg[k] <= dsum_c[k][33:14];
            end
            s6_sx_reg <= s5_sx_reg;
            s6_sy_reg <= s5_sy_reg;

            s7_m0_reg <= m0_c;
            s7_m1_reg <= m1_c;
            s7_a0_reg <= s6_d_reg[0];
            s7_a1_reg <= s6_d_reg[2];
            s7_sy_reg <= s6_sy_reg;

            s8_a_reg  <= la_c[DOT_W-1:0];
            s8_b_reg  <= lb_c[DOT_W-1:0];
            s8_sy_reg <= s7_sy_reg;

            s9_a_reg <= s8_a_reg;
            s9_m_reg <= my_c;

            s10_prod_reg <= wprod_c;
        end
    end

    // octave accumulation
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic signed [DOT_W-1:0] w_c;
    logic                    ds_v_reg;
    logic signed [SUM_W-1:0] ds_sum_reg;
    logic [DEN_W-1:0]        ds_den_reg;

    always_comb
    begin
        w_c      = tag_reg[NST].zero ? '0 : s10_prod_reg[35:16];
        acc_next = (tag_reg[NST].first ? '0 : acc_reg) + SUM_W'(w_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            ds_v_reg <= v_reg[NST] && tag_reg[NST].last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_reg[NST])
        begin
            acc_reg    <= acc_next;
            ds_sum_reg <= acc_next;
            ds_den_reg <= DEN_TWO - {1'b0, tag_reg[NST].scale_nx};
        end
    end

    // normalizing divider
    logic             dvv_reg [0:DIV_STAGES];
    div_t             dv_reg  [0:DIV_STAGES];
    logic             neg_c;
    logic [SUM_W-1:0] mag_c;
    logic             sat_c;
    div_t             init_c;
    logic signed [NOISE_W-1:0] q_c;
    logic             out_v_reg;
    logic [NOISE_W-1:0] out_data_reg;

    always_comb
    begin
        neg_c      = ds_sum_reg[SUM_W-1];
        mag_c      = neg_c ? SUM_W'(-ds_sum_reg) : SUM_W'(ds_sum_reg);
        sat_c      = (mag_c >= SUM_W'(ds_den_reg));
        init_c.neg = neg_c;
        init_c.sat = sat_c;
        init_c.rem = sat_c ? '0 : mag_c[DEN_W-1:0];
        init_c.quo = '0;
        init_c.den = ds_den_reg;
        if (dv_reg[DIV_STAGES].sat)
        begin
            q_c = dv_reg[DIV_STAGES].neg ? NOISE_MIN : NOISE_MAX;
        end
        else if (dv_reg[DIV_STAGES].neg)
        begin
            q_c = -$signed({1'b0, dv_reg[DIV_STAGES].quo});
        end
        else
        begin
            q_c = $signed({1'b0, dv_reg[DIV_STAGES].quo});
        end
    end

    assign adv = !(dvv_reg[DIV_STAGES] && out_v_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                dvv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dvv_reg[0] <= ds_v_reg;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                dvv_reg[k] <= dvv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= init_c;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                dv_reg[k] <= div_steps(dv_reg[k-1]);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv && dvv_reg[DIV_STAGES])
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && dvv_reg[DIV_STAGES])
        begin
            out_data_reg <= q_c;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    `GNFS_ASSERT(a_load_after_reads, clk, rst_n, (perm_we || grad_we) |-> !(v_reg[1] || v_reg[2] || v_reg[3]), "table write while octave reads in flight")
    `GNFS_ASSERT(a_zero_token, clk, rst_n, (v_reg[1] && tag_reg[1].zero) |-> (tag_reg[1].first && tag_reg[1].last), "empty evaluate not a single token")
    `GNFS_ASSERT(a_den_range, clk, rst_n, ds_v_reg |-> ((ds_den_reg > DEN_ONE) || ((ds_den_reg == DEN_ONE) && (ds_sum_reg == '0))), "divisor out of range")
    `GNFS_ASSERT_RST(a_reset_out, clk, !rst_n |=> !m_tvalid, "result valid after reset")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for gradient_noise_2d_fractal_sum: loads the tables, runs
// directed and random evaluates under several register settings and idling modes
// depends on gnfs_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
    import gnfs_pkg::*;

    localparam op_t      OP_UNUSED = 2'd3;
    localparam cfg_idx_t REG_NONE  = 2'd3;

    typedef struct {
        op_t         op;
        logic [7:0]  idx;
        logic [7:0]  perm;
        shortint     gx;
        shortint     gy;
        logic [31:0] cx;
        logic [31:0] cy;
    } noise_item_t;

    typedef struct {
        noise_item_t it;
        bit          typed;
        shortint     noise;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic [TUSER_W-1:0]    s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [NOISE_W-1:0]    m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [7:0]  perm_tab [256];
    shortint     gx_tab [256];
    shortint     gy_tab [256];
    int unsigned octaves_reg = 4;
    int unsigned persist_reg = 32768;
    int unsigned lacun_reg = 8192;

    shortint noise_q [$];
    int      err_cnt = 0;
    int      noise_seen = 0;
    int      evals_sent = 0;
    int      loads_sent = 0;
    int      src_pct = 0;
    int      sink_pct = 0;
    int      hold_left = 0;

    gradient_noise_2d_fractal_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint corner_dot(logic [7:0] c, longint rx, longint ry);
        return (longint'(gx_tab[c]) * rx + longint'(gy_tab[c]) * ry) >>> 14;
    endfunction

    function automatic longint fade(longint t);
        longint t2;
        t2 = (t * t) >>> 16;
        return (t2 * (196608 - 2 * t)) >>> 16;
    endfunction

    function automatic longint blend(longint s, longint a, longint b);
        return a + ((s * (b - a)) >>> 16);
    endfunction

    function automatic longint octave_noise(logic [31:0] px, logic [31:0] py);
        logic [7:0] bx0, bx1, by0, by1, i, j;
        longint     rx0, rx1, ry0, ry1, sx, sy, a, b;
        bx0 = px[23:16];
        bx1 = bx0 + 8'd1;
        by0 = py[23:16];
        by1 = by0 + 8'd1;
        rx0 = longint'(px[15:0]);
        rx1 = rx0 - 65536;
        ry0 = longint'(py[15:0]);
        ry1 = ry0 - 65536;
        i = perm_tab[bx0];
        j = perm_tab[bx1];
        sx = fade(rx0);
        sy = fade(ry0);
        a = blend(sx, corner_dot(perm_tab[8'(i + by0)], rx0, ry0),
                  corner_dot(perm_tab[8'(j + by0)], rx1, ry0));
        b = blend(sx, corner_dot(perm_tab[8'(i + by1)], rx0, ry1),
                  corner_dot(perm_tab[8'(j + by1)], rx1, ry1));
        return blend(sy, a, b);
    endfunction

    function automatic logic [31:0] scale_point(logic [31:0] p);
        longint v;
        v = (longint'($signed(p)) * longint'(lacun_reg)) >>> 12;
        return v[31:0];
    endfunction

    function automatic shortint fractal_noise(logic [31:0] px, logic [31:0] py);
        int unsigned n;
        longint      sum, scale, q;
        n = (octaves_reg > 16) ? 16 : octaves_reg;
        sum = 0;
        scale = 65536;
        for (int k = 0; k < n; k++)
        begin
            sum += (octave_noise(px, py) * scale) >>> 16;
            scale = (scale * longint'(persist_reg)) >>> 16;
            px = scale_point(px);
            py = scale_point(py);
        end
        q = (sum * 32768) / (131072 - scale);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return shortint'(q);
    endfunction

    // returns 1 when the item leaves a result
    function automatic bit apply_item(noise_item_t it, output shortint noise);
        noise = 0;
        case (it.op)
            OP_LOAD_PERM: perm_tab[it.idx] = it.perm;
            OP_LOAD_GRAD:
            begin
                gx_tab[it.idx] = it.gx;
                gy_tab[it.idx] = it.gy;
            end
            OP_EVAL:
            begin
                noise = fractal_noise(it.cx, it.cy);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic send_item(noise_item_t it, bit typed = 1'b0, shortint typed_noise = 0);
        shortint noise;
        if (src_pct > 0 && $urandom_range(99) < src_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        else
            @(negedge clk);
        s_tdata <= {it.cy, it.cx, it.gy, it.gx, it.perm, it.idx};
        s_tuser <= it.op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (apply_item(it, noise))
        begin
            noise_q.push_back(typed ? typed_noise : noise);
            evals_sent++;
        end
        else if (it.op != OP_UNUSED)
            loads_sent++;
    endtask

    task automatic stop_source();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        stop_source();
        while (noise_q.size() != 0)
            @(posedge clk);
        // loads may still be in flight behind the last result
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_OCTAVES: octaves_reg = val[4:0];
            REG_PERSIST: persist_reg = val;
            REG_LACUN:   lacun_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic noise_item_t make_item(op_t op, logic [7:0] idx, logic [7:0] perm,
                                              shortint gx, shortint gy,
                                              logic [31:0] cx, logic [31:0] cy);
        noise_item_t it;
        it.op = op;
        it.idx = idx;
        it.perm = perm;
        it.gx = gx;
        it.gy = gy;
        it.cx = cx;
        it.cy = cy;
        return it;
    endfunction

    // perm values stay below 16, so the perm loads made here point only at low gradient entries
    function automatic noise_item_t rand_item();
        int unsigned r;
        r = $urandom_range(99);
        return make_item(r < 70 ? OP_EVAL : r < 82 ? OP_LOAD_PERM : r < 94 ? OP_LOAD_GRAD
                         : OP_UNUSED,
                         8'($urandom), 8'($urandom_range(15)),
                         shortint'($signed($urandom_range(32768)) - 16384),
                         shortint'($signed($urandom_range(32768)) - 16384),
                         $urandom, $urandom);
    endfunction

    // sink with random stalls and an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_pct);
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            noise_seen++;
            if (noise_q.size() == 0)
            begin
                $error("noise_value: unexpected transfer, actual %0d", $signed(m_tdata));
                err_cnt++;
            end
            else if ($signed(m_tdata) != noise_q[0])
            begin
                $error("noise_value: expected %0d, actual %0d", noise_q[0],
                       $signed(m_tdata));
                err_cnt++;
                void'(noise_q.pop_front());
            end
            else
                void'(noise_q.pop_front());
        end
    end

    stim_row_t   dir_rows [$];
    int unsigned phase_oct [8] = '{1, 16, 31, 2, 5, 16, 8, 3};
    int unsigned phase_per [8] = '{0, 65535, 65535, 0, 32768, 12345, 50000, 65535};
    int unsigned phase_lac [8] = '{0, 65535, 4096, 65535, 8192, 3000, 9000, 0};

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // every entry an evaluate can reach is written before any evaluate
        for (int e = 0; e < 256; e++)
            send_item(make_item(OP_LOAD_PERM, 8'(e), 8'($urandom_range(15)), 0, 0, 0, 0));
        for (int e = 0; e < 16; e++)
            send_item(make_item(OP_LOAD_GRAD, 8'(e), 0,
                                shortint'($signed($urandom_range(32768)) - 16384),
                                shortint'($signed($urandom_range(32768)) - 16384), 0, 0));

        // directed: extremes of every field, every operation
        dir_rows = '{
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h0, 32'h0), 1'b1, 16'sd0},
            '{make_item(OP_LOAD_PERM, 8'd0, 8'd255, 0, 0, 0, 0), 1'b0, 0},
            '{make_item(OP_LOAD_PERM, 8'd255, 8'd0, 0, 0, 0, 0), 1'b0, 0},
            '{make_item(OP_LOAD_GRAD, 8'd0, 0, 16384, -16384, 0, 0), 1'b0, 0},
            '{make_item(OP_LOAD_GRAD, 8'd255, 0, -16384, 16384, 0, 0), 1'b0, 0},
            '{make_item(OP_LOAD_GRAD, 8'd1, 0, 16384, 16384, 0, 0), 1'b0, 0},
            '{make_item(OP_UNUSED, 8'd7, 8'd9, 0, 0, 32'hFFFF_FFFF, 0), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_FFFF), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h00FF_8000, 32'hFF00_8000), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h0000_8000, 32'h0001_4000), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h00FF_FFFF, 32'h00FF_0001), 1'b0, 0},
            '{make_item(OP_EVAL, 0, 0, 0, 0, 32'h0000_0000, 32'h0000_0000), 1'b1, 16'sd0}
        };
        foreach (dir_rows[r])
            send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].noise);
        drain();

        // zero octaves sums nothing
        write_reg(REG_OCTAVES, 16'd0);
        send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'h1234_5678, 32'h8765_4321), 1'b1, 16'sd0);
        send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1, 16'sd0);
        drain();
        write_reg(REG_NONE, 16'hFFFF);

        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_OCTAVES, 16'(phase_oct[p]));
            write_reg(REG_PERSIST, 16'(phase_per[p]));
            write_reg(REG_LACUN, 16'(phase_lac[p]));
            src_pct = (p % 4 == 1) ? 70 : (p % 4 == 3) ? 16 : 0;
            sink_pct = (p % 4 == 2) ? 70 : (p % 4 == 3) ? 16 : 0;
            if (p == 2)
                hold_left = 400;
            for (int n = 0; n < 16; n++)
            begin
                send_item(rand_item());
                if (p == 5 && n == 8)
                begin
                    // sender waits for every result before going on
                    stop_source();
                    while (noise_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        write_reg(REG_OCTAVES, 16'($urandom_range(31)));
        write_reg(REG_PERSIST, 16'($urandom));
        write_reg(REG_LACUN, 16'($urandom));
        src_pct = 16;
        sink_pct = 16;
        for (int n = 0; n < 32; n++)
            send_item(rand_item());
        drain();

        $display("covered %0d evaluates and %0d table loads over 11 register settings",
                 evals_sent, loads_sent);
        $display("%0d noise results checked, %0d mismatches", noise_seen, err_cnt);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
